// ===== src/histogram_min_max_mode_macros.svh =====
// Assertion macros shared by the checker of the histogram block.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef HISTOGRAM_MIN_MAX_MODE_MACROS_SVH
`define HISTOGRAM_MIN_MAX_MODE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HMM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hmm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hmm assertion failed");

`endif

// ===== src/hmm_pkg.sv =====
// Package of the histogram min/max/mode block: widths, defaults and types.
// Used by the interfaces, the core, the output queue and the top level.
package hmm_pkg;

    localparam int VALUE_W         = 9;
    localparam int DEF_VALUE_RANGE = 512;
    localparam int DEF_COUNT_LIMIT = 1024;
    // Set tag stored next to each count; the table is swept when it wraps.
    localparam int EPOCH_W         = 8;
    localparam int OFIFO_DEPTH     = 4;

    typedef logic [VALUE_W-1:0] t_value;

    localparam t_value VALUE_ALL_ONES = '1;

    typedef struct packed {
        t_value min_value;
        t_value max_value;
        t_value mode_value;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result result;
    } t_push;

endpackage

// ===== src/hmm_ifs.sv =====
// Valid/ready channel interfaces for the histogram block.
// Depends on hmm_pkg for the payload types.
interface hmm_in_if;
    logic            valid;
    logic            ready;
    hmm_pkg::t_value sample_value;
    logic            last_item;

    modport source (output valid, output sample_value, output last_item, input ready);
    modport sink   (input valid, input sample_value, input last_item, output ready);
endinterface

interface hmm_res_if;
    logic            valid;
    logic            ready;
    hmm_pkg::t_value min_value;
    hmm_pkg::t_value max_value;
    hmm_pkg::t_value mode_value;

    modport source (output valid, output min_value, output max_value, output mode_value,
                    input ready);
    modport sink   (input valid, input min_value, input max_value, input mode_value,
                    output ready);
endinterface

// ===== src/histogram_min_max_mode.sv =====
// Streaming histogram with running min, max and mode; one request per cycle while ready.
// A request reads the count table when taken and writes it back the next cycle;
// the result of a last request is pushed into the result queue as it is written back.
// Reset clears min, max and mode and starts a sweep of the count table with ready low;
// every 256th set stalls for a new sweep; a full result queue holds ready low.
// Depends on hmm_pkg, hmm_ifs, hmm_core and hmm_ofifo.
module histogram_min_max_mode #(
    parameter int VALUE_RANGE = hmm_pkg::DEF_VALUE_RANGE,
    parameter int COUNT_LIMIT = hmm_pkg::DEF_COUNT_LIMIT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hmm_in_if.sink    i_in,
    hmm_res_if.source o_res
);

    logic           room;
    logic           ready;
    hmm_pkg::t_push push;

    assign i_in.ready = ready;

    hmm_core #(
        .VALUE_RANGE (VALUE_RANGE),
        .COUNT_LIMIT (COUNT_LIMIT)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in.valid),
        .o_ready        (ready),
        .i_sample_value (i_in.sample_value),
        .i_last_item    (i_in.last_item),
        .i_room         (room),
        .o_push         (push)
    );

    hmm_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_res   (o_res)
    );

endmodule

// ===== src/hmm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module hmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// ===== src/hmm_core.sv =====
// Histogram read-modify-write pipeline with running min, max and mode.
// Depends on hmm_pkg and hmm_ram; the count table lives in one hmm_ram.
module hmm_core #(
    parameter int VALUE_RANGE = hmm_pkg::DEF_VALUE_RANGE,
    parameter int COUNT_LIMIT = hmm_pkg::DEF_COUNT_LIMIT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  hmm_pkg::t_value i_sample_value,
    input  logic            i_last_item,
    input  logic            i_room,
    output hmm_pkg::t_push  o_push
);

    localparam int AW = $clog2(VALUE_RANGE);
    localparam int CW = $clog2(COUNT_LIMIT + 1);
    localparam int EW = hmm_pkg::EPOCH_W;
    localparam int MW = EW + CW;
    localparam logic [AW-1:0] LAST_ADDR = AW'(VALUE_RANGE - 1);
    localparam logic [CW-1:0] COUNT_CAP = CW'(COUNT_LIMIT);

    logic            accept;
    logic            in_range;
    logic            fwd_hit;
    logic            s1_wr;
    logic            wrap;
    logic [AW-1:0]   rd_addr;
    logic [MW-1:0]   rd_data;
    logic [EW-1:0]   rd_tag;
    logic [CW-1:0]   rd_count;
    logic [CW-1:0]   stored;
    logic [CW-1:0]   s1_count;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [MW-1:0]   wr_data;

    logic            r_s1_valid;
    logic            r_s1_last;
    logic            r_s1_in_range;
    hmm_pkg::t_value r_s1_value;
    logic            r_fwd_hit;
    logic [CW-1:0]   r_fwd_count;
    logic [EW-1:0]   r_epoch;
    logic            r_sweep;
    logic [AW-1:0]   r_sweep_addr;
    hmm_pkg::t_value r_min;
    hmm_pkg::t_value r_max;
    hmm_pkg::t_value r_best_value;
    logic [CW-1:0]   r_best_count;

    hmm_pkg::t_value n_min;
    hmm_pkg::t_value n_max;
    hmm_pkg::t_value n_best_value;
    logic [CW-1:0]   n_best_count;

    // A set that wraps the tag must wait for the sweep before new reads start.
    assign wrap     = r_s1_valid && r_s1_last && (&r_epoch);
    assign o_ready  = !r_sweep && !wrap && i_room;
    assign accept   = i_valid && o_ready;
    assign in_range = (32'(i_sample_value) < VALUE_RANGE);
    assign rd_addr  = AW'(i_sample_value);
    assign s1_wr    = r_s1_valid && r_s1_in_range;

    // The entry written this cycle is not yet visible to the read issued now.
    assign fwd_hit  = s1_wr && !r_s1_last && (r_s1_value == i_sample_value);

    assign rd_tag   = rd_data[MW-1:CW];
    assign rd_count = rd_data[CW-1:0];

    always_comb begin
        if (r_fwd_hit) begin
            stored = r_fwd_count;
        end else if (rd_tag == r_epoch) begin
            stored = rd_count;
        end else begin
            stored = '0;
        end
        s1_count = (stored < COUNT_CAP) ? stored + CW'(1) : stored;
    end

    always_comb begin
        n_min        = r_min;
        n_max        = r_max;
        n_best_value = r_best_value;
        n_best_count = r_best_count;
        if (s1_wr) begin
            if (r_s1_value < r_min) begin
                n_min = r_s1_value;
            end
            if (r_s1_value > r_max) begin
                n_max = r_s1_value;
            end
            if (s1_count > r_best_count) begin
                n_best_value = r_s1_value;
                n_best_count = s1_count;
            end
        end
    end

    always_comb begin
        o_push.valid             = r_s1_valid && r_s1_last;
        o_push.result.min_value  = n_min;
        o_push.result.max_value  = n_max;
        o_push.result.mode_value = n_best_value;
    end

    always_comb begin
        wr_en = s1_wr || r_sweep;
        if (r_sweep) begin
            wr_addr = r_sweep_addr;
            wr_data = '0;
        end else begin
            wr_addr = AW'(r_s1_value);
            wr_data = {r_epoch, s1_count};
        end
    end

    hmm_ram #(
        .WIDTH (MW),
        .DEPTH (VALUE_RANGE)
    ) u_count_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_fwd_hit    <= 1'b0;
            r_epoch      <= '0;
            r_sweep      <= 1'b1;
            r_sweep_addr <= '0;
            r_min        <= hmm_pkg::VALUE_ALL_ONES;
            r_max        <= '0;
            r_best_value <= '0;
            r_best_count <= '0;
        end else begin
            r_s1_valid <= accept;
            r_fwd_hit  <= accept && fwd_hit;
            if (r_s1_valid && r_s1_last) begin
                r_min        <= hmm_pkg::VALUE_ALL_ONES;
                r_max        <= '0;
                r_best_value <= '0;
                r_best_count <= '0;
                r_epoch      <= r_epoch + EW'(1);
            end else begin
                r_min        <= n_min;
                r_max        <= n_max;
                r_best_value <= n_best_value;
                r_best_count <= n_best_count;
            end
            if (wrap) begin
                r_sweep      <= 1'b1;
                r_sweep_addr <= '0;
            end else if (r_sweep) begin
                r_sweep_addr <= r_sweep_addr + AW'(1);
                if (r_sweep_addr == LAST_ADDR) begin
                    r_sweep <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_last     <= i_last_item;
        r_s1_in_range <= in_range;
        r_s1_value    <= i_sample_value;
        r_fwd_count   <= s1_count;
    end

endmodule

// ===== src/hmm_ofifo.sv =====
// Small result queue that decouples the pipeline from the result channel.
// Depends on hmm_pkg and the hmm_res_if interface.
module hmm_ofifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hmm_pkg::t_push i_push,
    output logic           o_room,
    hmm_res_if.source      o_res
);

    localparam int DEPTH = hmm_pkg::OFIFO_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);
    localparam int SW    = CNTW + 1;

    hmm_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0]    r_rd_ptr;
    logic [PW-1:0]    r_wr_ptr;
    logic [CNTW-1:0]  r_count;
    logic             pop;

    assign pop = (r_count != '0) && o_res.ready;

    // Room must also cover the result that the pipeline pushes this cycle.
    assign o_room = (SW'(r_count) + SW'(i_push.valid)) < SW'(DEPTH);

    assign o_res.valid      = (r_count != '0);
    assign o_res.min_value  = r_mem[r_rd_ptr].min_value;
    assign o_res.max_value  = r_mem[r_rd_ptr].max_value;
    assign o_res.mode_value = r_mem[r_rd_ptr].mode_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            case ({i_push.valid, pop})
                2'b10:   r_count <= r_count + CNTW'(1);
                2'b01:   r_count <= r_count - CNTW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.result;
        end
    end

endmodule

// ===== src/hmm_checker.sv =====
// Port-level checker for the histogram block, bound to the top level.
// Depends on histogram_min_max_mode_macros.svh for the assertion macros.
`include "histogram_min_max_mode_macros.svh"

module hmm_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input hmm_pkg::t_value i_min_value,
    input hmm_pkg::t_value i_max_value,
    input hmm_pkg::t_value i_mode_value
);

    // A result that is not taken stays offered.
    `HMM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // Right after reset the table sweep is running and nothing is queued.
    `HMM_ASSERT_IMP(a_after_reset, i_clk, i_rst_n, !$past(i_rst_n), !i_in_ready && !i_out_valid)

    // For a set with counted values the mode lies between min and max.
    `HMM_ASSERT_IMP(a_mode_range, i_clk, i_rst_n, i_out_valid && (i_min_value <= i_max_value), (i_mode_value >= i_min_value) && (i_mode_value <= i_max_value))

    // A set with no counted value reports the cleared state.
    `HMM_ASSERT_IMP(a_empty_set, i_clk, i_rst_n, i_out_valid && (i_min_value > i_max_value), (i_min_value == hmm_pkg::VALUE_ALL_ONES) && (i_max_value == '0) && (i_mode_value == '0))

endmodule

bind histogram_min_max_mode hmm_checker u_hmm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_min_value  (o_res.min_value),
    .i_max_value  (o_res.max_value),
    .i_mode_value (o_res.mode_value)
);

// ===== test/tb_top.sv =====
// Testbench of histogram_min_max_mode: random and directed sets of samples go in,
// each set summary (min, max, mode) is predicted in the bench and checked on arrival.
// Depends on hmm_pkg, hmm_ifs and the block's RTL.
module tb_top;

    localparam int VAL_RANGE     = hmm_pkg::DEF_VALUE_RANGE;
    localparam int SAT_COUNT     = hmm_pkg::DEF_COUNT_LIMIT;
    localparam int COUNT_W       = 11;
    localparam int QUIET_LIMIT   = 4000;
    localparam int PHASE_LEN     = 200;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int MIN_SETS      = 264;

    typedef enum int {PH_NO_IDLE, PH_SRC_IDLE, PH_SINK_STALL, PH_BOTH_IDLE} t_phase;

    typedef struct packed {
        hmm_pkg::t_value value;
        logic            last;
    } t_sample;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hmm_in_if  in_if ();
    hmm_res_if res_if ();

    histogram_min_max_mode #(
        .VALUE_RANGE(VAL_RANGE),
        .COUNT_LIMIT(SAT_COUNT)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_res  (res_if)
    );

    always #5 i_clk = ~i_clk;

    // Bench copy of the histogram and the running set state.
    bit [COUNT_W-1:0] tally [VAL_RANGE];
    hmm_pkg::t_value  run_min;
    hmm_pkg::t_value  run_max;
    hmm_pkg::t_value  top_value;
    bit [COUNT_W-1:0] top_count;

    t_sample          pending_samples[$];
    hmm_pkg::t_result expected_summaries[$];
    t_sample          next_sample;
    hmm_pkg::t_result want;

    int items_queued;
    int sets_queued;
    int samples_taken;
    int summaries_seen;
    int mismatches;
    int quiet_cycles;

    function automatic void clear_tally();
        foreach (tally[k]) tally[k] = '0;
        run_min   = hmm_pkg::VALUE_ALL_ONES;
        run_max   = '0;
        top_value = '0;
        top_count = '0;
    endfunction

    function automatic void tally_sample(hmm_pkg::t_value value, logic last);
        hmm_pkg::t_result summary;
        if (int'(value) < VAL_RANGE) begin
            if (value < run_min) run_min = value;
            if (value > run_max) run_max = value;
            if (tally[value] < SAT_COUNT) tally[value] = tally[value] + 1'b1;
            // Strictly greater: on a tie the value that got there first keeps the mode.
            if (tally[value] > top_count) begin
                top_count = tally[value];
                top_value = value;
            end
        end
        if (last) begin
            summary.min_value  = run_min;
            summary.max_value  = run_max;
            summary.mode_value = top_value;
            expected_summaries.insert(expected_summaries.size(), summary);
            clear_tally();
        end
    endfunction

    function automatic int idle_pct(bit sender);
        t_phase ph;
        ph = t_phase'((samples_taken / PHASE_LEN) % 4);
        case (ph)
            PH_SRC_IDLE:   return sender ? 55 : 0;
            PH_SINK_STALL: return sender ? 0 : 55;
            PH_BOTH_IDLE:  return 14;
            default:       return 0;
        endcase
    endfunction

    function automatic void add_sample(hmm_pkg::t_value value, logic last);
        t_sample s;
        s.value = value;
        s.last  = last;
        pending_samples.insert(pending_samples.size(), s);
        items_queued++;
        if (last) sets_queued++;
    endfunction

    function automatic void add_random_set();
        int              len;
        int              style;
        hmm_pkg::t_value base;
        hmm_pkg::t_value v;
        len   = ($urandom_range(15) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        style = $urandom_range(2);
        base  = hmm_pkg::t_value'($urandom_range(VAL_RANGE - 4));
        for (int k = 0; k < len; k++) begin
            case (style)
                0:       v = hmm_pkg::t_value'($urandom_range(VAL_RANGE - 1));
                // A narrow window makes repeats and ties common.
                1:       v = base + hmm_pkg::t_value'($urandom_range(3));
                default: v = $urandom_range(1) ? hmm_pkg::t_value'($urandom_range(1))
                                               : hmm_pkg::VALUE_ALL_ONES
                                                 - hmm_pkg::t_value'($urandom_range(1));
            endcase
            add_sample(v, k == len - 1);
        end
    endfunction

    task automatic report_mismatch(string what, int got, int exp_val);
        $display("tb_top: mismatch in %s at %0t: got %0d, expected %0d",
                 what, $realtime, got, exp_val);
        mismatches++;
    endtask

    // Request driver: valid holds until the request is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                tally_sample(in_if.sample_value, in_if.last_item);
                samples_taken++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
                    next_sample = pending_samples.pop_front();
                    in_if.valid        <= 1'b1;
                    in_if.sample_value <= next_sample.value;
                    in_if.last_item    <= next_sample.last;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and checker.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                summaries_seen++;
                if (expected_summaries.size() == 0) begin
                    report_mismatch("result with no set pending", res_if.mode_value, -1);
                end else begin
                    want = expected_summaries.pop_front();
                    if (res_if.min_value !== want.min_value)
                        report_mismatch("min_value", res_if.min_value, want.min_value);
                    if (res_if.max_value !== want.max_value)
                        report_mismatch("max_value", res_if.max_value, want.max_value);
                    if (res_if.mode_value !== want.mode_value)
                        report_mismatch("mode_value", res_if.mode_value, want.mode_value);
                end
            end
            res_if.ready <= ($urandom_range(99) >= idle_pct(1'b0));
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.sample_value = '0;
        in_if.last_item    = 1'b0;
        res_if.ready       = 1'b0;
        clear_tally();

        // Extremes, a tie, bit patterns and a check that the table clears between sets.
        add_sample(hmm_pkg::t_value'(0), 1'b1);
        add_sample(hmm_pkg::VALUE_ALL_ONES, 1'b1);
        add_sample(hmm_pkg::t_value'(5), 1'b0);
        add_sample(hmm_pkg::t_value'(7), 1'b0);
        add_sample(hmm_pkg::t_value'(7), 1'b0);
        add_sample(hmm_pkg::t_value'(5), 1'b1);
        add_sample(hmm_pkg::VALUE_ALL_ONES, 1'b0);
        add_sample(hmm_pkg::t_value'(0), 1'b0);
        add_sample(hmm_pkg::t_value'(256), 1'b0);
        add_sample(hmm_pkg::t_value'(0), 1'b1);
        add_sample(hmm_pkg::t_value'(9'h155), 1'b0);
        add_sample(hmm_pkg::t_value'(9'h0AA), 1'b0);
        add_sample(hmm_pkg::t_value'(9'h0AA), 1'b1);
        add_sample(hmm_pkg::t_value'(3), 1'b0);
        add_sample(hmm_pkg::t_value'(3), 1'b1);
        add_sample(hmm_pkg::t_value'(9), 1'b0);
        add_sample(hmm_pkg::t_value'(3), 1'b1);
        add_sample(hmm_pkg::t_value'(1), 1'b1);
        add_sample(hmm_pkg::VALUE_ALL_ONES - 1'b1, 1'b0);
        add_sample(hmm_pkg::VALUE_ALL_ONES, 1'b0);
        add_sample(hmm_pkg::VALUE_ALL_ONES - 1'b1, 1'b1);

        // Enough short sets to pass the point where the block sweeps its table again.
        while (items_queued < RANDOM_ITEMS || sets_queued < MIN_SETS) begin
            add_random_set();
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_samples.size() != 0 || in_if.valid || expected_summaries.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("tb_top: %0d samples in %0d sets sent, %0d summaries checked",
                 samples_taken, sets_queued, summaries_seen);
        $display("tb_top: covered ties, repeats, the periodic table sweep and four idle mixes");
        if (mismatches == 0 && expected_summaries.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
